// ===== hw/rtl/sfc_pkg.sv =====
// Shared types and constants for the SPI frame CRC-8 checker.
// Used by the CRC byte update, the frame controller, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sfc_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_POLYNOMIAL = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL    = 8'd1;

   // Register reset values.
   localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;
   localparam logic [BYTE_W-1:0] INIT_RESET = 8'h00;

   typedef struct packed {
      logic [BYTE_W-1:0] polynomial;
      logic [BYTE_W-1:0] initial_value;
   } cfg_type;

   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] first_payload;
      logic [BYTE_W-1:0] second_payload;
   } result_type;

endpackage

// ===== hw/rtl/sfc_crc_byte.sv =====
// One-byte MSB-first CRC-8 update, unrolled over the eight bit steps.
// Depends on sfc_pkg for the byte width.
`timescale 1ns / 1ps

module sfc_crc_byte
   import sfc_pkg::*;
(
   input  logic [BYTE_W-1:0] crc,
   input  logic [BYTE_W-1:0] data,
   input  logic [BYTE_W-1:0] polynomial,
   output logic [BYTE_W-1:0] crc_next
);

   localparam logic [BYTE_W-1:0] TOP_BIT = 8'h80;

   logic [BYTE_W-1:0] v;

   always_comb begin
      v = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((v & TOP_BIT) != '0) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ polynomial;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      crc_next = v;
   end

endmodule

// ===== hw/rtl/sfc_frame_ctrl.sv =====
// Frame controller: byte position counter, held payload and running CRC.
// Depends on sfc_pkg and sfc_crc_byte.
`timescale 1ns / 1ps

module sfc_frame_ctrl
   import sfc_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 2
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              advance,
   input  logic [BYTE_W-1:0] rx_byte,
   output result_type        result
);

   localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 1);
   localparam logic [POS_W-1:0] CHECK_POS = POS_W'(PAYLOAD_BYTES);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] first_ff;
   logic [BYTE_W-1:0] second_ff;
   logic [BYTE_W-1:0] crc_start;
   logic [BYTE_W-1:0] crc_next;
   logic              is_check;

   assign is_check  = (pos_ff == CHECK_POS);
   assign crc_start = (pos_ff == '0) ? cfg.initial_value : crc_ff;

   sfc_crc_byte u_crc (
      .crc        (crc_start),
      .data       (rx_byte),
      .polynomial (cfg.polynomial),
      .crc_next   (crc_next)
   );

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (advance) begin
         if (is_check) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= INIT_RESET;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Only the first two payload bytes ever leave the block.
   always_ff @(posedge clock) begin
      if (advance && pos_ff == POS_W'(0)) begin
         first_ff <= rx_byte;
      end
      if (advance && PAYLOAD_BYTES >= 2 && pos_ff == POS_W'(1)) begin
         second_ff <= rx_byte;
      end
   end

   always_comb begin
      result.hit            = advance && is_check && (rx_byte == crc_ff);
      result.first_payload  = first_ff;
      result.second_payload = (PAYLOAD_BYTES >= 2) ? second_ff : '0;
   end

endmodule

// ===== hw/rtl/spi_frame_crc8_checker_core.sv =====
// A frame's result is registered: its check byte transfer loads the input register,
// and a passing frame's payload goes into the result register once it is free or draining.
// Throughput: one byte per cycle while the result register is free or draining.
// Reset clears the byte position, the input and result valid flags, and sets
// the polynomial register to 0x07 and the initial value register to 0x00.
`timescale 1ns / 1ps

module spi_frame_crc8_checker_core
   import sfc_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 2
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_first_payload,
   output logic [BYTE_W-1:0]      rsp_second_payload
);

   cfg_type           cfg_ff, cfg_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] first_ff;
   logic [BYTE_W-1:0] second_ff;
   logic              advance;
   result_type        result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_POLYNOMIAL) begin
            cfg_in.polynomial = csr_wdata;
         end else if (csr_index == CSR_INITIAL) begin
            cfg_in.initial_value = csr_wdata;
         end
      end
   end

   // The held byte moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && result.hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial    <= POLY_RESET;
         cfg_ff.initial_value <= INIT_RESET;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.hit) begin
         first_ff  <= result.first_payload;
         second_ff <= result.second_payload;
      end
   end

   sfc_frame_ctrl #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_payload  = first_ff;
   assign rsp_second_payload = second_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for spi_frame_crc8_checker_core: drives byte streams
// and register writes, predicts the passed frames and checks every result.
// Depends on sfc_pkg and the core module only.
`timescale 1ns / 1ps

module testbench;
   import sfc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 150;
   localparam int PHASE_BYTES = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] first_payload;
      logic [BYTE_W-1:0] second_payload;
   } payload_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_W-1:0]      rsp_first_payload;
   logic [BYTE_W-1:0]      rsp_second_payload;

   // Predictor state: our own copy of the registers and the frame tracker.
   logic [BYTE_W-1:0] poly_cfg = POLY_RESET;
   logic [BYTE_W-1:0] init_cfg = INIT_RESET;
   logic [1:0]        frame_pos = 2'd0;
   logic [BYTE_W-1:0] frame_bytes [0:1];
   logic [BYTE_W-1:0] frame_crc = INIT_RESET;

   logic [BYTE_W-1:0] rx_pending [$];
   payload_pair_type  passed_frames [$];

   int unsigned bytes_queued = 0;
   int unsigned gen_pos = 0;
   int          src_idle_pct = 16;
   int          sink_idle_pct = 16;
   int          error_count = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   bit          hold_go = 1'b0;
   bit          hold_done = 1'b0;

   spi_frame_crc8_checker_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_payload  (rsp_first_payload),
      .rsp_second_payload (rsp_second_payload)
   );

   always #4 clock = ~clock;

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      for (int k = 0; k < BYTE_W; k++)
         v = v[BYTE_W-1] ? ((v << 1) ^ poly) : (v << 1);
      return v;
   endfunction

   // Byte driver; the frame predictor runs on every accepted transfer.
   always @(posedge clock) begin
      payload_pair_type pair;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (frame_pos < 2'd2) begin
               frame_bytes[frame_pos[0]] = req_rx_byte;
               frame_crc = crc8_step((frame_pos == 2'd0) ? init_cfg : frame_crc,
                                     req_rx_byte, poly_cfg);
               frame_pos = frame_pos + 2'd1;
            end else begin
               frame_pos = 2'd0;
               if (req_rx_byte == frame_crc) begin
                  pair.first_payload  = frame_bytes[0];
                  pair.second_payload = frame_bytes[1];
                  passed_frames.push_back(pair);
               end
            end
         end
         if (!req_valid || req_ready) begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      payload_pair_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (passed_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %02h %02h",
                        $time, rsp_first_payload, rsp_second_payload);
               error_count++;
            end else begin
               want = passed_frames.pop_front();
               if (rsp_first_payload !== want.first_payload) begin
                  $display("%0t: first_payload expected %02h, got %02h",
                           $time, want.first_payload, rsp_first_payload);
                  error_count++;
               end
               if (rsp_second_payload !== want.second_payload) begin
                  $display("%0t: second_payload expected %02h, got %02h",
                           $time, want.second_payload, rsp_second_payload);
                  error_count++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Long receiver hold-off so that the core backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      rx_pending.push_back(b);
      bytes_queued++;
      gen_pos = (gen_pos == 2) ? 0 : gen_pos + 1;
   endtask

   // Pads the stream back onto a frame boundary before queuing the frame.
   task automatic push_frame(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                             input bit good);
      logic [BYTE_W-1:0] crc;
      while (gen_pos != 0)
         push_byte(BYTE_W'($urandom_range(255)));
      crc = crc8_step(crc8_step(init_cfg, a, poly_cfg), b, poly_cfg);
      push_byte(a);
      push_byte(b);
      push_byte(good ? crc : crc ^ BYTE_W'($urandom_range(255, 1)));
   endtask

   task automatic wait_until_quiet();
      do @(negedge clock);
      while (rx_pending.size() != 0 || req_valid || passed_frames.size() != 0);
      // A dropped frame leaves nothing to wait on, so give the pipeline time.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [BYTE_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         CSR_POLYNOMIAL: poly_cfg = data;
         CSR_INITIAL:    init_cfg = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] poly, input logic [BYTE_W-1:0] init,
                            input int src_pct, input int sink_pct);
      int unsigned stop_at;
      int          pick;
      write_csr(CSR_POLYNOMIAL, poly);
      write_csr(CSR_INITIAL, init);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      stop_at = bytes_queued + PHASE_BYTES;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 72)
            push_frame(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 1'b1);
         else if (pick < 88)
            push_frame(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 1'b0);
         else
            repeat ($urandom_range(2, 1)) push_byte(BYTE_W'($urandom_range(255)));
      end
      wait_until_quiet();
   endtask

   initial begin
      logic [BYTE_W-1:0] old_poly;
      logic [BYTE_W-1:0] old_init;
      logic [BYTE_W-1:0] check;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset register values, field extremes and a failed check.
      push_frame(8'h00, 8'h00, 1'b1);
      push_frame(8'hFF, 8'hFF, 1'b1);
      push_frame(8'hA5, 8'h5A, 1'b0);
      push_frame(8'h80, 8'h01, 1'b1);
      wait_until_quiet();

      // Register extremes; writes to unused indexes must change nothing.
      write_csr(CSR_POLYNOMIAL, 8'h00);
      write_csr(CSR_INITIAL, 8'hFF);
      write_csr(CSR_INDEX_W'(CSR_INITIAL + 1), 8'h5C);
      write_csr({CSR_INDEX_W{1'b1}}, 8'hC5);
      push_frame(8'h12, 8'h34, 1'b1);
      push_frame(8'hFE, 8'h7F, 1'b0);
      wait_until_quiet();

      // Registers change in the middle of a frame: the new polynomial applies
      // to the next byte, the new start value only to the next frame.
      push_byte(8'hC3);
      wait_until_quiet();
      old_poly = poly_cfg;
      old_init = init_cfg;
      write_csr(CSR_POLYNOMIAL, 8'h31);
      write_csr(CSR_INITIAL, 8'h55);
      check = crc8_step(crc8_step(old_init, 8'hC3, old_poly), 8'h3C, poly_cfg);
      push_byte(8'h3C);
      push_byte(check);
      push_frame(8'h01, 8'h80, 1'b1);
      wait_until_quiet();

      run_phase(POLY_RESET, INIT_RESET, 16, 16);
      run_phase(8'hFF, 8'hFF, 0, 0);
      hold_go = 1'b1;
      run_phase(8'h00, 8'h00, 0, 16);
      repeat (4) begin
         write_csr(CSR_INDEX_W'($urandom_range({CSR_INDEX_W{1'b1}}, CSR_INITIAL + 1)),
                   BYTE_W'($urandom_range(255)));
         run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 16, 16);
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
